// ===== hdl/krg_pkg.sv =====
// Shared types and constants for the key repeat generator.
// Used by krg_ctrl, krg_datapath and key_repeat_generator_unit; no dependencies.
package krg_pkg;

  localparam int DEF_HELD_SLOTS = 8;
  localparam int DEF_KEY_BITS   = 8;

  localparam int KEY_PORT_W  = 8;
  localparam int DELAY_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int MAX_RESULTS = 8;
  localparam int SCNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int OIDX_W      = $clog2(MAX_RESULTS);

  localparam logic [DELAY_W-1:0] BASE_DELAY_RST = 16'd250;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_IDLE    = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_DELAY   = 3'd0,
    REG_FIRST_DELAY  = 3'd1,
    REG_ACCEL_STEP   = 3'd2,
    REG_ACCEL_BEGIN  = 3'd3,
    REG_ACCEL_SPAN   = 3'd4,
    REG_EMIT_PRESS   = 3'd5,
    REG_EMIT_RELEASE = 3'd6
  } cfg_reg_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic eval;
    logic mul;
    logic write;
    logic find;
    logic act;
    logic emit;
    logic idx_inc;
  } krg_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fire;
    logic idx_last;
    logic emit_last;
    logic sort_empty;
  } krg_sts_t;

endpackage

// ===== hdl/krg_ctrl.sv =====
// Sequencer for the key repeat generator: slot sweep, reload steps, result emission.
// Depends on krg_pkg.
module krg_ctrl import krg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] action,
  input  krg_sts_t   sts,
  output krg_cmd_t   cmd,
  output logic       busy
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_WRITE = 7'b0001000,
    S_EMIT  = 7'b0010000,
    S_FIND  = 7'b0100000,
    S_ACT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (action) inside
            ACT_TICK:              state_next = S_EVAL;
            ACT_PRESS, ACT_RELEASE: state_next = S_FIND;
            default:               state_next = S_IDLE;
          endcase
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.fire) begin
          state_next = S_MUL;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = sts.idx_last ? S_EMIT : S_EVAL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = sts.idx_last ? S_EMIT : S_EVAL;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.sort_empty || sts.emit_last) state_next = S_IDLE;
      end
      S_FIND: begin
        cmd.find    = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) state_next = S_ACT;
      end
      S_ACT: begin
        cmd.act    = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hdl/krg_datapath.sv =====
// Datapath of the key repeat generator: config registers, held-key slot table,
// reload multiplier, sorted result buffer and output registers. Depends on krg_pkg.
module krg_datapath import krg_pkg::*; #(
  parameter int HELD_SLOTS = DEF_HELD_SLOTS,
  parameter int KEY_BITS   = DEF_KEY_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  krg_cmd_t              cmd,
  output krg_sts_t              sts,
  input  logic [1:0]            action,
  input  logic [KEY_PORT_W-1:0] key_code,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  strobe,
  output logic [KEY_PORT_W-1:0] repeat_key,
  output logic                  last
);

  localparam int KB    = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int IDX_W = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;

  // configuration
  logic [DELAY_W-1:0] base_delay;
  logic [DELAY_W-1:0] first_delay;
  logic [DELAY_W-1:0] accel_step;
  logic [DELAY_W-1:0] accel_begin;
  logic [DELAY_W-1:0] accel_span;
  logic               emit_on_press;
  logic               emit_on_release;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay      <= BASE_DELAY_RST;
      first_delay     <= '0;
      accel_step      <= '0;
      accel_begin     <= '0;
      accel_span      <= '0;
      emit_on_press   <= 1'b0;
      emit_on_release <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_DELAY:   base_delay      <= cfg_data;
        REG_FIRST_DELAY:  first_delay     <= cfg_data;
        REG_ACCEL_STEP:   accel_step      <= cfg_data;
        REG_ACCEL_BEGIN:  accel_begin     <= cfg_data;
        REG_ACCEL_SPAN:   accel_span      <= cfg_data;
        REG_EMIT_PRESS:   emit_on_press   <= cfg_data[0];
        REG_EMIT_RELEASE: emit_on_release <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // captured input word
  logic [1:0]    act_q;
  logic [KB-1:0] key_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= action;
      key_q <= key_code[KB-1:0];
    end
  end

  // slot sweep index
  logic [IDX_W-1:0] idx;
  logic             idx_last;

  assign idx_last = (idx == IDX_W'(HELD_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_last ? '0 : idx + 1'b1;
    end
  end

  // held-key table
  logic               slot_used [HELD_SLOTS];
  logic [KB-1:0]      slot_key  [HELD_SLOTS];
  logic [DELAY_W-1:0] slot_rem  [HELD_SLOTS];
  logic [DELAY_W-1:0] slot_reps [HELD_SLOTS];

  logic               cur_used;
  logic [KB-1:0]      cur_key;
  logic [DELAY_W-1:0] cur_rem;
  logic [DELAY_W-1:0] cur_reps;
  logic               fire;

  assign cur_used = slot_used[idx];
  assign cur_key  = slot_key[idx];
  assign cur_rem  = slot_rem[idx];
  assign cur_reps = slot_reps[idx];
  assign fire     = cur_used && (cur_rem == '0);

  // press / release lookup results
  logic             match_found;
  logic [IDX_W-1:0] match_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             press_ok;
  logic             release_ok;

  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (cmd.find) begin
      if (cur_used && (cur_key == key_q)) begin
        match_found <= 1'b1;
        match_idx   <= idx;
      end
      if (!cur_used && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
    end
  end

  assign press_ok   = (act_q == ACT_PRESS) && !match_found && free_found;
  assign release_ok = (act_q == ACT_RELEASE) && match_found;

  // reload delay: stage 1 count and ramp position
  logic [DELAY_W-1:0] reps_new;
  logic [DELAY_W:0]   ramp_end;
  logic [DELAY_W-1:0] reps_new_q;
  logic [DELAY_W-1:0] k_q;
  logic               accel_q;

  assign reps_new = (cur_reps == '1) ? cur_reps : cur_reps + 1'b1;
  assign ramp_end = {1'b0, accel_begin} + {1'b0, accel_span};

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      reps_new_q <= reps_new;
      accel_q    <= (accel_step != '0) && (accel_begin < reps_new);
      k_q        <= ({1'b0, reps_new} < ramp_end) ? reps_new - accel_begin : accel_span;
    end
  end

  // stage 2 reduction product
  logic [2*DELAY_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= accel_step * k_q;
    end
  end

  // stage 3 saturated delay
  logic [DELAY_W-1:0] delay;
  logic [DELAY_W-1:0] new_rem;
  logic [DELAY_W-1:0] init_rem;

  always_comb begin
    if (!accel_q) begin
      delay = base_delay;
    end else if (prod >= {{DELAY_W{1'b0}}, base_delay}) begin
      delay = '0;
    end else begin
      delay = base_delay - prod[DELAY_W-1:0];
    end
    if (delay == '0) delay = DELAY_W'(1);
    new_rem = delay - 1'b1;
  end

  assign init_rem = (first_delay != '0) ? first_delay : base_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HELD_SLOTS; i++) slot_used[i] <= 1'b0;
    end else if (cmd.act) begin
      if (press_ok)   slot_used[free_idx]  <= 1'b1;
      if (release_ok) slot_used[match_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && cur_used && (cur_rem != '0)) begin
      slot_rem[idx] <= cur_rem - 1'b1;
    end
    if (cmd.write) begin
      slot_rem[idx]  <= new_rem;
      slot_reps[idx] <= reps_new_q;
    end
    if (cmd.act && press_ok) begin
      slot_key[free_idx]  <= key_q;
      slot_rem[free_idx]  <= init_rem;
      slot_reps[free_idx] <= '0;
    end
  end

  // sorted buffer of the smallest fired keys
  logic [KB-1:0]     sbuf      [MAX_RESULTS];
  logic [KB-1:0]     sbuf_next [MAX_RESULTS];
  logic [MAX_RESULTS-1:0] lt;
  logic [SCNT_W-1:0] scnt;
  logic [OIDX_W-1:0] ocnt;
  logic              sort_empty;
  logic              emit_last;

  always_comb begin
    for (int j = 0; j < MAX_RESULTS; j++) begin
      lt[j] = (SCNT_W'(j) < scnt) && (sbuf[j] < cur_key);
    end
    sbuf_next[0] = lt[0] ? sbuf[0] : cur_key;
    for (int j = 1; j < MAX_RESULTS; j++) begin
      if (lt[j]) begin
        sbuf_next[j] = sbuf[j];
      end else if (lt[j-1]) begin
        sbuf_next[j] = cur_key;
      end else begin
        sbuf_next[j] = sbuf[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      for (int j = 0; j < MAX_RESULTS; j++) sbuf[j] <= sbuf_next[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      scnt <= '0;
      ocnt <= '0;
    end else begin
      if (cmd.write && (scnt != SCNT_W'(MAX_RESULTS))) scnt <= scnt + 1'b1;
      if (cmd.emit && !sort_empty) ocnt <= ocnt + 1'b1;
    end
  end

  assign sort_empty = (scnt == '0);
  assign emit_last  = ((SCNT_W'(ocnt) + 1'b1) == scnt);

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (cmd.emit && !sort_empty) ||
                (cmd.act && ((press_ok && emit_on_press) || (release_ok && emit_on_release)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      repeat_key <= KEY_PORT_W'(sbuf[ocnt]);
      last       <= emit_last;
    end else if (cmd.act) begin
      repeat_key <= KEY_PORT_W'(key_q);
      last       <= 1'b1;
    end
  end

  assign sts.fire       = fire;
  assign sts.idx_last   = idx_last;
  assign sts.emit_last  = emit_last;
  assign sts.sort_empty = sort_empty;

endmodule

// ===== hdl/key_repeat_generator_unit.sv =====
// Key repeat generator, top level: joins krg_ctrl and krg_datapath.
// Depends on krg_pkg, krg_ctrl, krg_datapath.
//
// A word is taken when start is high and busy is low; busy stays high until
// every repeat it causes has been issued. A tick sweeps the HELD_SLOTS entries
// one per cycle, but each entry that fires holds the sweep for the reload
// multiply and write-back; the results then leave one per cycle, ascending by
// key, on consecutive strobes, at most min(F,8) results for F firing keys. A
// press or release sweeps the table for the key and a free slot, then updates
// the table. The receiver cannot stall: each result is valid for the single
// cycle strobe is high, in the cycle after it is produced. Configuration
// writes are always ready and take effect at once; write them only while busy
// is low and no result is pending.
module key_repeat_generator_unit import krg_pkg::*; #(
  parameter int HELD_SLOTS = DEF_HELD_SLOTS,
  parameter int KEY_BITS   = DEF_KEY_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            action,
  input  logic [KEY_PORT_W-1:0] key_code,
  output logic                  strobe,
  output logic [KEY_PORT_W-1:0] repeat_key,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  krg_cmd_t cmd;
  krg_sts_t sts;

  assign cfg_ready = 1'b1;

  krg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  krg_datapath #(
    .HELD_SLOTS (HELD_SLOTS),
    .KEY_BITS   (KEY_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .action     (action),
    .key_code   (key_code),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .strobe     (strobe),
    .repeat_key (repeat_key),
    .last       (last)
  );

`ifndef SYNTH
  // results of one input leave as an unbroken burst
  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("result burst broken before last word");

  // the next input needs a full sweep before it can produce a word
  a_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("word issued right after a last word");

  // any valid action taken while idle raises busy in the following cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (action != ACT_IDLE) |=> busy)
    else $error("accepted word did not raise busy");
`endif

endmodule
